### design/lpc_pkg.sv
// Shared widths and defaults for the lattice path counter.
package lpc_pkg;
  localparam int DIM_W   = 5;
  localparam int COUNT_W = 30;
  localparam int MAX_DIM = 16;
endpackage

### design/lpc_if.sv
// Request and response channel interfaces of the lattice path counter.
interface lpc_req_if;
  import lpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] height;
  logic [DIM_W-1:0] width;
  modport source (output valid, output height, output width, input ready);
  modport sink (input valid, input height, input width, output ready);
endinterface

interface lpc_rsp_if;
  import lpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] path_count;
  logic               too_large;
  modport source (output valid, output path_count, output too_large, input ready);
  modport sink (input valid, input path_count, input too_large, output ready);
endinterface

### design/lpc_ram.sv
// Generic simple dual-port RAM with registered read.
module lpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/lattice_path_counter.sv
// Lattice path counter: row-by-row count over a scratch RAM, one cell per cycle within a row.
// One word at a time; the next word is accepted once the result is registered.
// The single read and single write port of the row RAM set the pace of one cell per cycle.
// Reset clears the control state only; the row RAM is filled with ones for each in-range word with nonzero dimensions.
module lattice_path_counter #(
  parameter int MAX_DIM = lpc_pkg::MAX_DIM
) (
  input logic clk,
  input logic rst,
  lpc_req_if.sink   req,
  lpc_rsp_if.source rsp
);
  import lpc_pkg::*;

  localparam int DEPTH = MAX_DIM + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DIM + 2);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FILL   = 3'd1;
  localparam logic [2:0] S_ROW    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]         state;
  logic [AW-1:0]      h_dim;
  logic [AW-1:0]      w_dim;
  logic [AW-1:0]      row;
  logic [CW-1:0]      col;
  logic [COUNT_W-1:0] prev;
  logic [COUNT_W-1:0] res_count;
  logic               res_err;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;

  logic [CW-1:0]      wr_col;
  logic [COUNT_W-1:0] sum;
  logic               row_end;
  logic               req_big;

  assign req.ready = (state == S_IDLE);
  assign req_big   = (req.height > DIM_W'(MAX_DIM)) || (req.width > DIM_W'(MAX_DIM));
  assign wr_col    = col - CW'(1);
  assign sum       = prev + ram_rdata;
  assign row_end   = (wr_col == CW'(w_dim));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col[AW-1:0];
    ram_wdata = COUNT_W'(1);
    ram_raddr = col[AW-1:0];
    unique case (state)
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_ROW: begin
        ram_raddr = AW'(1);
      end
      S_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = wr_col[AW-1:0];
        ram_wdata = sum;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lpc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_FINISH) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            h_dim <= req.height[AW-1:0];
            w_dim <= req.width[AW-1:0];
            col   <= '0;
            row   <= '0;
            if (req_big) begin
              res_count <= '0;
              res_err   <= 1'b1;
              state     <= S_FINISH;
            end else if (req.height == '0 || req.width == '0) begin
              res_count <= COUNT_W'(1);
              res_err   <= 1'b0;
              state     <= S_FINISH;
            end else begin
              state <= S_FILL;
            end
          end
        end
        S_FILL: begin
          if (col == CW'(w_dim)) begin
            state <= S_ROW;
          end else begin
            col <= col + CW'(1);
          end
        end
        S_ROW: begin
          prev  <= COUNT_W'(1);
          col   <= CW'(2);
          state <= S_SCAN;
        end
        S_SCAN: begin
          prev <= sum;
          col  <= col + CW'(1);
          if (row_end) begin
            if (row == h_dim - AW'(1)) begin
              res_count <= sum;
              res_err   <= 1'b0;
              state     <= S_FINISH;
            end else begin
              row   <= row + AW'(1);
              state <= S_ROW;
            end
          end
        end
        S_FINISH: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.path_count <= res_count;
            rsp.too_large  <= res_err;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.too_large |-> rsp.path_count == '0)
    else $error("error result carries a nonzero count");

  a_big_finish: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req_big |=> state == S_FINISH)
    else $error("oversized request did not go straight to finish");

  a_scan_col: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (wr_col >= CW'(1)) && (wr_col <= CW'(w_dim)))
    else $error("scan write column out of range");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && !row_end |-> ram_raddr != ram_waddr)
    else $error("row RAM read and write hit the same entry");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROW || state == S_SCAN) |-> row < h_dim)
    else $error("row counter passed the height");
endmodule

### dv/tb_lattice_path_counter.sv
// Testbench for lattice_path_counter: random and directed lattices checked against a local count.
`timescale 1ns / 100ps

module tb_lattice_path_counter;
  import lpc_pkg::*;

  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] w;
    int               gap;
    bit               drain_first;
    bit               hold_sink;
  } lattice_req_t;

  typedef struct {
    logic [DIM_W-1:0]   h;
    logic [DIM_W-1:0]   w;
    logic [COUNT_W-1:0] count;
    logic               too_large;
  } lattice_result_t;

  logic clk = 1'b0;
  logic rst;

  lpc_req_if req ();
  lpc_rsp_if rsp ();

  lattice_path_counter dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  lattice_req_t       dim_queue [$];
  lattice_result_t    count_queue [$];
  logic [COUNT_W-1:0] row_sums [MAX_DIM+1];
  int                 mismatch_cnt = 0;
  int                 gap_left;
  int                 hold_kick;
  int                 hold_seen;
  int                 hold_left;
  int                 stall_left;
  int                 calm_left;
  int                 calm_items = 0;
  int                 idle_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic lattice_result_t count_paths(logic [DIM_W-1:0] h, logic [DIM_W-1:0] w);
    lattice_result_t res;
    res.h = h;
    res.w = w;
    if (h > MAX_DIM || w > MAX_DIM) begin
      res.count     = '0;
      res.too_large = 1'b1;
    end else begin
      for (int c = 0; c <= w; c++) row_sums[c] = COUNT_W'(1);
      for (int r = 0; r < h; r++)
        for (int c = 1; c <= w; c++) row_sums[c] = row_sums[c] + row_sums[c-1];
      res.count     = row_sums[w];
      res.too_large = 1'b0;
    end
    return res;
  endfunction

  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(99);
    if (calm_items != 0) begin
      calm_items--;
      return 0;
    end
    if (pick < 3) begin
      calm_items = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  task automatic queue_dims(input int h, input int w, input bit drain, input bit hold);
    lattice_req_t item;
    item.h           = DIM_W'(h);
    item.w           = DIM_W'(w);
    item.gap         = draw_gap();
    item.drain_first = drain;
    item.hold_sink   = hold;
    dim_queue.push_back(item);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid  <= 1'b0;
      req.height <= '0;
      req.width  <= '0;
      gap_left   <= 0;
      hold_kick  <= 0;
    end else begin
      if (req.valid && req.ready) count_queue.push_back(count_paths(req.height, req.width));
      if (!req.valid || req.ready) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          req.valid <= 1'b0;
        end else if (dim_queue.size() != 0 &&
                     !(dim_queue[0].drain_first && count_queue.size() != 0)) begin
          req.valid  <= 1'b1;
          req.height <= dim_queue[0].h;
          req.width  <= dim_queue[0].w;
          gap_left   <= dim_queue[0].gap;
          if (dim_queue[0].hold_sink) hold_kick <= hold_kick + 1;
          void'(dim_queue.pop_front());
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and response backpressure
  always @(posedge clk) begin : sink_side
    lattice_result_t want;
    int              pick;
    if (rst) begin
      rsp.ready  <= 1'b0;
      hold_seen  <= 0;
      hold_left  <= 0;
      stall_left <= 0;
      calm_left  <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (count_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected word count=%0d too_large=%0b",
                                    rsp.path_count, rsp.too_large));
        end else begin
          want = count_queue.pop_front();
          if (rsp.path_count !== want.count)
            report_mismatch($sformatf("h=%0d w=%0d path_count %0d, want %0d",
                                      want.h, want.w, rsp.path_count, want.count));
          if (rsp.too_large !== want.too_large)
            report_mismatch($sformatf("h=%0d w=%0d too_large %0b, want %0b",
                                      want.h, want.w, rsp.too_large, want.too_large));
        end
      end
      pick = $urandom_range(99);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp.ready <= 1'b0;
      end else if (hold_seen != hold_kick) begin
        hold_seen <= hold_kick;
        hold_left <= HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rsp.ready  <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left <= calm_left - 1;
        rsp.ready <= 1'b1;
      end else if (pick < 2) begin
        calm_left <= $urandom_range(100, 300);
        rsp.ready <= 1'b1;
      end else if (pick < 22) begin
        stall_left <= $urandom_range(0, 2);
        rsp.ready  <= 1'b0;
      end else if (pick < 25) begin
        stall_left <= $urandom_range(10, 60);
        rsp.ready  <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("lattice_path_counter verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int pick;
    int h;
    int w;
    rst = 1'b1;

    queue_dims(0, 0, 0, 0);
    queue_dims(0, 1, 0, 0);
    queue_dims(1, 0, 0, 0);
    queue_dims(1, 1, 0, 1);
    queue_dims(0, 16, 0, 0);
    queue_dims(16, 0, 0, 0);
    queue_dims(16, 16, 0, 0);
    queue_dims(16, 15, 0, 0);
    queue_dims(15, 16, 0, 0);
    queue_dims(1, 16, 0, 0);
    queue_dims(16, 1, 0, 0);
    queue_dims(2, 3, 0, 0);
    queue_dims(17, 0, 1, 0);
    queue_dims(0, 17, 0, 0);
    queue_dims(17, 17, 0, 0);
    queue_dims(31, 31, 0, 0);
    queue_dims(31, 0, 0, 0);
    queue_dims(0, 31, 0, 0);
    queue_dims(16, 17, 0, 0);
    queue_dims(17, 16, 0, 0);
    queue_dims(10, 21, 0, 0);
    queue_dims(21, 10, 0, 0);
    queue_dims(8, 8, 0, 0);

    for (int i = 0; i < 1400; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        h = $urandom_range(0, 3);
        w = $urandom_range(0, 3);
      end else if (pick < 75) begin
        h = $urandom_range(0, MAX_DIM);
        w = $urandom_range(0, MAX_DIM);
      end else if (pick < 88) begin
        h = $urandom_range(MAX_DIM + 1, 31);
        w = $urandom_range(0, 31);
        if ($urandom_range(1)) begin
          pick = h;
          h    = w;
          w    = pick;
        end
      end else if (pick < 93) begin
        h = MAX_DIM;
        w = $urandom_range(0, MAX_DIM);
        if ($urandom_range(1)) begin
          pick = h;
          h    = w;
          w    = pick;
        end
      end else begin
        h = $urandom_range(0, 31);
        w = $urandom_range(0, 31);
      end
      queue_dims(h, w, (i % 200) == 199, i == 700);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (dim_queue.size() != 0 || req.valid || count_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("lattice_path_counter verification clean");
    end else begin
      $display("lattice_path_counter verification failed");
    end
    $finish;
  end

endmodule
